/* hw/rtl/ptdt_pkg.sv */
`default_nettype none

package ptdt_pkg;

	// Input operation codes
	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_STEP       = 3'd1;
	localparam logic [2:0] OP_BUTTON     = 3'd2;
	localparam logic [2:0] OP_TILT       = 3'd3;
	localparam logic [2:0] OP_CLR_SNOOZE = 3'd4;

	// Release classification codes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_REMIND_PERIOD = 2'd0;
	localparam logic [1:0] CFG_LONG_PRESS    = 2'd1;
	localparam logic [1:0] CFG_SIP           = 2'd2;

	// Register reset values
	localparam logic [3:0]  REMIND_PERIOD_RST = 4'd2;
	localparam logic [15:0] LONG_PRESS_RST    = 16'd30;
	localparam logic [15:0] SIP_RST           = 16'd20;
	localparam logic [5:0]  COUNTDOWN_RST     = 6'd10;

	// Period limits for the countdown reload
	localparam logic [3:0] PERIOD_MIN = 4'd1;
	localparam logic [3:0] PERIOD_MAX = 4'd10;

	typedef logic [1:0] kind_t;

	// Countdown reload: clamped period times five (4p + p)
	function automatic logic [5:0] reload_value(input logic [3:0] period);
		logic [3:0] p;
		p = period;
		if (p < PERIOD_MIN) p = PERIOD_MIN;
		if (p > PERIOD_MAX) p = PERIOD_MAX;
		return {p, 2'b00} + {2'b00, p};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/press_tilt_duration_timer_top.sv */
// Press, tilt and reminder duration timer. A button (active low), a tilt
// sensor and a reminder countdown share one tick counter that runs while
// any of them is active. Each request on s_* is one event (tick, countdown
// step, button level, tilt level, clear snooze) and yields exactly one
// result on m_*. One request is taken every clock cycle while s_tready is
// high; its result appears in the output register the cycle after, which
// also decouples the two sides, so s_tready stays high while that register
// is empty or being drained. Configuration writes take effect at the clock
// edge of cfg_we and should be made while no request is in flight.
`default_nettype none

module press_tilt_duration_timer_top
	import ptdt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [15:0] cfg_wdata,
	// event requests
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [2:0] op, [3] level, [7:4] zero
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata    // [1:0] press_kind, [3:2] tilt_kind,
	                                    // [4] reminder_due, [5] timer_running,
	                                    // [37:6] tick_now, [39:38] zero
);

	// configuration
	logic [3:0]  remind_period_q;
	logic [15:0] long_press_q;
	logic [15:0] sip_q;

	// channel state
	logic [31:0] tick_q;
	logic        ticking_q;
	logic        button_q;
	logic        tilt_q;
	logic        snooze_q;
	logic [31:0] button_start_q;
	logic [31:0] tilt_start_q;
	logic [5:0]  countdown_q;

	// output register
	logic        out_valid_q;
	logic [39:0] out_data_q;

	// next state
	logic [31:0] tick_d;
	logic        ticking_d;
	logic        button_d;
	logic        tilt_d;
	logic        snooze_d;
	logic [31:0] button_start_d;
	logic [31:0] tilt_start_d;
	logic [5:0]  countdown_d;
	logic [5:0]  cd_dec;
	logic        due;
	kind_t       press_kind;
	kind_t       tilt_kind;
	kind_t       press_eval;
	kind_t       tilt_eval;

	logic [2:0]  op;
	logic        level;
	logic        accept;

	assign op       = s_tdata[2:0];
	assign level    = s_tdata[3];
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign cd_dec   = countdown_q - 6'd1;

	// release classifiers
	ptdt_dur u_press_dur (
		.tick_now (tick_q),
		.start    (button_start_q),
		.thresh   (long_press_q),
		.held     (button_q),
		.kind     (press_eval)
	);

	ptdt_dur u_tilt_dur (
		.tick_now (tick_q),
		.start    (tilt_start_q),
		.thresh   (sip_q),
		.held     (tilt_q),
		.kind     (tilt_eval)
	);

	// event decode and state update
	always_comb begin
		tick_d         = tick_q;
		ticking_d      = ticking_q;
		button_d       = button_q;
		tilt_d         = tilt_q;
		snooze_d       = snooze_q;
		button_start_d = button_start_q;
		tilt_start_d   = tilt_start_q;
		countdown_d    = countdown_q;
		due            = 1'b0;
		press_kind     = KIND_NONE;
		tilt_kind      = KIND_NONE;
		case (op)
			OP_TICK: begin
				if (ticking_q) tick_d = tick_q + 32'd1;
			end
			OP_STEP: begin
				if (cd_dec == 6'd0) begin
					snooze_d    = 1'b1;
					countdown_d = reload_value(remind_period_q);
					due         = 1'b1;
					if (!tilt_q && !button_q) begin
						tick_d    = 32'd0;
						ticking_d = 1'b1;
					end
				end else begin
					countdown_d = cd_dec;
				end
			end
			OP_BUTTON: begin
				if (!level) begin
					button_d = 1'b1;
					if (!tilt_q && !snooze_q) begin
						tick_d    = 32'd0;
						ticking_d = 1'b1;
					end
					button_start_d = tick_d;
				end else begin
					press_kind = press_eval;
					button_d   = 1'b0;
					if (!tilt_q && !snooze_q) ticking_d = 1'b0;
				end
			end
			OP_TILT: begin
				if (level) begin
					tilt_d = 1'b1;
					if (!button_q && !snooze_q) begin
						tick_d    = 32'd0;
						ticking_d = 1'b1;
					end
					tilt_start_d = tick_d;
				end else begin
					tilt_kind = tilt_eval;
					tilt_d    = 1'b0;
					if (!button_q && !snooze_q) ticking_d = 1'b0;
				end
			end
			OP_CLR_SNOOZE: begin
				snooze_d = 1'b0;
				if (!button_q && !tilt_q) ticking_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remind_period_q <= REMIND_PERIOD_RST;
			long_press_q    <= LONG_PRESS_RST;
			sip_q           <= SIP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_REMIND_PERIOD: remind_period_q <= cfg_wdata[3:0];
				CFG_LONG_PRESS:    long_press_q    <= cfg_wdata;
				CFG_SIP:           sip_q           <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// channel state, updated per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= 32'd0;
			ticking_q      <= 1'b0;
			button_q       <= 1'b0;
			tilt_q         <= 1'b0;
			snooze_q       <= 1'b0;
			button_start_q <= 32'd0;
			tilt_start_q   <= 32'd0;
			countdown_q    <= COUNTDOWN_RST;
		end else if (accept) begin
			tick_q         <= tick_d;
			ticking_q      <= ticking_d;
			button_q       <= button_d;
			tilt_q         <= tilt_d;
			snooze_q       <= snooze_d;
			button_start_q <= button_start_d;
			tilt_start_q   <= tilt_start_d;
			countdown_q    <= countdown_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {2'b00, tick_d, ticking_d, due, tilt_kind, press_kind};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

/* hw/rtl/ptdt_dur.sv */
`default_nettype none

// Classifies a channel release: elapsed ticks against a threshold
module ptdt_dur
	import ptdt_pkg::*;
(
	input  wire logic [31:0] tick_now,
	input  wire logic [31:0] start,
	input  wire logic [15:0] thresh,
	input  wire logic        held,
	output kind_t            kind
);

	logic [31:0] elapsed;

	// elapsed wraps modulo 2^32
	assign elapsed = tick_now - start;

	always_comb begin
		if (!held) begin
			kind = KIND_NONE;
		end else if (elapsed > {16'd0, thresh}) begin
			kind = KIND_LONG;
		end else begin
			kind = KIND_SHORT;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/ptdt_checker.sv */
`default_nettype none

module ptdt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// empty output register never blocks requests
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request blocked with empty output");

	// kinds only take defined codes
	a_kinds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3)
		else $error("undefined kind code");

	// a reminder holds the snooze channel, so the counter runs
	a_due_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[5])
		else $error("reminder with counter stopped");

endmodule

bind press_tilt_duration_timer_top ptdt_checker u_ptdt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
